FILE: rtl/tlapa_pkg.sv
// Shared types and constants for the two-link arm pixel angle pipeline.
// Used by the cell modules and the top level; depends on nothing else.
package tlapa_pkg;

	localparam int DIM_W     = 13;
	localparam int COORD_W   = 12;
	localparam int COLOR_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// divider: one quotient bit per cell
	localparam int QUO_W = 33;
	localparam int REM_W = DIM_W;

	// coordinates, offsets and squared radius
	localparam int XY_W  = 24;
	localparam int LEN_W = 25;
	localparam int SQ_W  = 48;
	localparam int Q_W   = 29;

	// square root: two radicand bits per cell
	localparam int RAD_W  = 56;
	localparam int ROOT_W = 28;
	localparam int SREM_W = 30;

	// CORDIC
	localparam int CW           = 34;
	localparam int ZW           = 20;
	localparam int CORDIC_STEPS = 16;
	localparam int LANES        = 3;

	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2
	};
	localparam logic signed [ZW-1:0] QUARTER_TURN = 20'sd102944;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] nq;
	} dl_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		dl_t              xl;
		dl_t              yl;
	} dv_t;

	typedef struct packed {
		logic                    oor;
		logic [Q_W-1:0]          q;
		logic signed [LEN_W-1:0] u;
		logic signed [LEN_W-1:0] v;
		logic [RAD_W-1:0]        rad;
		logic [SREM_W-1:0]       rem;
		logic [ROOT_W-1:0]       root;
	} sq_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cl_t;

	typedef struct packed {
		logic                oor;
		cl_t [LANES-1:0]     lane;
	} cd_t;

endpackage

FILE: rtl/tlapa_div_cell.sv
// One restoring-divider cell: resolves one quotient bit for both coordinates.
// Depends on tlapa_pkg.
module tlapa_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           prev_valid,
	input  tlapa_pkg::dv_t prev,
	output logic           next_valid,
	output tlapa_pkg::dv_t next
);
	import tlapa_pkg::*;

	function automatic dl_t div_step(input dl_t l, input logic [DIM_W-1:0] d);
		logic [REM_W:0] t;
		logic           fits;
		dl_t            r;
		t      = {l.rem, l.nq[QUO_W-1]};
		fits   = (t >= {1'b0, d});
		r.nq   = {l.nq[QUO_W-2:0], fits};
		r.rem  = fits ? REM_W'(t - {1'b0, d}) : t[REM_W-1:0];
		return r;
	endfunction

	dv_t  step;
	logic valid_q;
	dv_t  data_q;

	always_comb begin
		step    = prev;
		step.xl = div_step(prev.xl, prev.w);
		step.yl = div_step(prev.yl, prev.w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= step;
		end
	end

	assign next_valid = valid_q;
	assign next       = data_q;
endmodule

FILE: rtl/tlapa_sqrt_cell.sv
// One digit-by-digit square-root cell: takes two radicand bits, gives one root bit.
// Depends on tlapa_pkg.
module tlapa_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           prev_valid,
	input  tlapa_pkg::sq_t prev,
	output logic           next_valid,
	output tlapa_pkg::sq_t next
);
	import tlapa_pkg::*;

	logic [SREM_W+1:0] t;
	logic [SREM_W+1:0] trial;
	logic              fits;
	sq_t               step;
	logic              valid_q;
	sq_t               data_q;

	always_comb begin
		t         = {prev.rem, prev.rad[RAD_W-1 -: 2]};
		trial     = (SREM_W+2)'({prev.root, 2'b01});
		fits      = (t >= trial);
		step      = prev;
		step.rem  = fits ? SREM_W'(t - trial) : SREM_W'(t);
		step.root = {prev.root[ROOT_W-2:0], fits};
		step.rad  = {prev.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= step;
		end
	end

	assign next_valid = valid_q;
	assign next       = data_q;
endmodule

FILE: rtl/tlapa_cordic_cell.sv
// One CORDIC vectoring cell: a fixed-shift micro-rotation on three lanes.
// Depends on tlapa_pkg.
module tlapa_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           prev_valid,
	input  tlapa_pkg::cd_t prev,
	output logic           next_valid,
	output tlapa_pkg::cd_t next
);
	import tlapa_pkg::*;

	// x moves by the shifted y and y moves by the shifted x
	function automatic cl_t rotate(input cl_t l);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		cl_t                  r;
		dx = l.y >>> STEP;
		dy = l.x >>> STEP;
		if (!l.y[CW-1]) begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + ATAN_TAB[STEP];
		end else begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - ATAN_TAB[STEP];
		end
		return r;
	endfunction

	cd_t  step;
	logic valid_q;
	cd_t  data_q;

	always_comb begin
		step = prev;
		for (int k = 0; k < LANES; k++) begin
			step.lane[k] = rotate(prev.lane[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= step;
		end
	end

	assign next_valid = valid_q;
	assign next       = data_q;
endmodule

FILE: rtl/two_link_arm_pixel_angles.sv
// Top level of the two-link arm pixel angle pipeline.
// Depends on tlapa_pkg, tlapa_div_cell, tlapa_sqrt_cell and tlapa_cordic_cell.

// Each beat on the input carries one pixel; a pure black pixel yields one result
// beat with the lower and upper servo angles in whole degrees, or out_of_reach
// set with both angles zero, and any other color yields nothing. The block takes
// one pixel per clock while in_stall is low; every black pixel passes through
// three cell chains (33 divider cells for the pixel-to-centimetre scale, 28
// square-root cells for the law of cosines, 16 CORDIC cells running the three
// arctangents side by side) plus the input, multiply and rounding stages. A
// stall on a held result freezes the whole pipeline, so in_stall rises only in
// a cycle where a result is held on the output and the consumer stalls it.
// image_width and image_height are written through the cfg port (cfg_ready is
// always high), by the user only while no pixel is in flight, which the block
// itself does not enforce; values of zero or above MAX_DIM act as 1 and MAX_DIM.
module two_link_arm_pixel_angles #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tlapa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlapa_pkg::DIM_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tlapa_pkg::COORD_W-1:0]       column,
	input  logic [tlapa_pkg::COORD_W-1:0]       row,
	input  logic [tlapa_pkg::COLOR_W-1:0]       red,
	input  logic [tlapa_pkg::COLOR_W-1:0]       green,
	input  logic [tlapa_pkg::COLOR_W-1:0]       blue,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          lower_arm_angle,
	output logic signed [8:0]                   upper_arm_angle,
	output logic                                out_of_reach
);
	import tlapa_pkg::*;

	localparam logic [16:0]            MaxDimV   = 17'(MAX_DIM);
	localparam logic [20:0]            PaperQ    = 21'd1966080;     // 30 cm in Q16
	localparam logic signed [QUO_W:0]  PaperS    = 34'sd1966080;
	localparam logic signed [LEN_W-1:0] OffsetD  = 25'sd810967;     // 17.5/sqrt(2) cm
	localparam logic [SQ_W:0]          ReachLo   = 49'd107374182400;   // 25 cm^2
	localparam logic [SQ_W:0]          ReachHi   = 49'd18146236825600; // 4225 cm^2
	localparam logic [Q_W-1:0]         InnerQ    = 29'd1638400;
	localparam logic [Q_W-1:0]         OuterQ    = 29'd276889600;
	localparam logic signed [CW-1:0]   ElbowQ    = 34'sd139264000;  // 2125 cm^2
	localparam logic signed [CW-1:0]   ShoulderQ = 34'sd21299200;   // 325 cm^2
	localparam int                     PW        = 44;
	localparam logic signed [PW-1:0]   RadToDeg  = 44'sd3754936;
	localparam logic signed [PW-1:0]   HalfLsb   = 44'sd32768;
	localparam logic signed [PW-1:0]   RightQ    = 44'sd5898240;    // 90 degrees in Q16

	function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [QUO_W:0] d);
		logic signed [XY_W-1:0] r;
		if (d > 34'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (d < -34'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = d[XY_W-1:0];
		end
		return r;
	endfunction

	// Bring a vector into the right half plane, as the vectoring mode needs.
	function automatic cl_t pre_rotate(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		cl_t r;
		if (!x[CW-1]) begin
			r.x = x;
			r.y = y;
			r.z = '0;
		end else if (!y[CW-1]) begin
			r.x = y;
			r.y = -x;
			r.z = QUARTER_TURN;
		end else begin
			r.x = -y;
			r.y = x;
			r.z = -QUARTER_TURN;
		end
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] e;
		if (r == '0) begin
			e = DIM_W'(1);
		end else if (17'(r) > MaxDimV) begin
			e = MaxDimV[DIM_W-1:0];
		end else begin
			e = r;
		end
		return e;
	endfunction

	// ---------------------------------------------------------------- control
	logic             adv;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Freeze everything only while a held result is stalled.
	assign in_stall  = out_valid & out_stall;
	assign adv       = ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Drop non-black pixels here; clamp the dimensions and apply the last
	// column / last row rule.
	logic             black;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             valid_s1;
	logic [DIM_W-1:0] w_s1;
	logic [DIM_W-1:0] ci_s1;
	logic [DIM_W-1:0] rj_s1;

	assign black = ((red | green | blue) == '0);
	assign w_eff = eff_dim(width_q);
	assign h_eff = eff_dim(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid & black;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1  <= w_eff;
			ci_s1 <= DIM_W'(column) + DIM_W'((DIM_W'(column) + DIM_W'(1)) == w_eff);
			rj_s1 <= DIM_W'(row) + DIM_W'((DIM_W'(row) + DIM_W'(1)) == h_eff);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Scale numerator with the half-divisor rounding term.
	logic valid_s2;
	dv_t  dv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s2.w      <= w_s1;
			dv_s2.xl.rem <= '0;
			dv_s2.yl.rem <= '0;
			dv_s2.xl.nq  <= QUO_W'(QUO_W'(PaperQ) * QUO_W'(ci_s1)) + QUO_W'(w_s1 >> 1);
			dv_s2.yl.nq  <= QUO_W'(QUO_W'(PaperQ) * QUO_W'(rj_s1)) + QUO_W'(w_s1 >> 1);
		end
	end

	// ---------------------------------------------------------------- divider chain
	dv_t            dv_c  [QUO_W+1];
	logic [QUO_W:0] dvv_c;

	assign dv_c[0]  = dv_s2;
	assign dvv_c[0] = valid_s2;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		tlapa_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (adv),
			.prev_valid (dvv_c[g]),
			.prev       (dv_c[g]),
			.next_valid (dvv_c[g+1]),
			.next       (dv_c[g+1])
		);
	end

	// ---------------------------------------------------------------- stage 3
	// Paper coordinates, saturated, then offsets from the arm base.
	logic signed [XY_W-1:0]  x_c;
	logic signed [XY_W-1:0]  y_c;
	logic                    valid_s3;
	logic signed [LEN_W-1:0] u_s3;
	logic signed [LEN_W-1:0] v_s3;

	assign x_c = sat_xy($signed({1'b0, dv_c[QUO_W].xl.nq}) - PaperS);
	assign y_c = sat_xy(PaperS - $signed({1'b0, dv_c[QUO_W].yl.nq}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= dvv_c[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s3 <= OffsetD - LEN_W'(x_c);
			v_s3 <= LEN_W'(y_c) + OffsetD;
		end
	end

	// ---------------------------------------------------------------- stage 4
	logic signed [2*LEN_W-1:0] uu_c;
	logic signed [2*LEN_W-1:0] vv_c;
	logic                      valid_s4;
	logic [SQ_W-1:0]           uu_s4;
	logic [SQ_W-1:0]           vv_s4;
	logic signed [LEN_W-1:0]   u_s4;
	logic signed [LEN_W-1:0]   v_s4;

	assign uu_c = u_s3 * u_s3;
	assign vv_c = v_s3 * v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			uu_s4 <= uu_c[SQ_W-1:0];
			vv_s4 <= vv_c[SQ_W-1:0];
			u_s4  <= u_s3;
			v_s4  <= v_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	logic                    valid_s5;
	logic [SQ_W:0]           r2_s5;
	logic signed [LEN_W-1:0] u_s5;
	logic signed [LEN_W-1:0] v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s5 <= {1'b0, uu_s4} + {1'b0, vv_s4};
			u_s5  <= u_s4;
			v_s5  <= v_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Reach test and the two factors under the cosine-law root.
	logic [Q_W-1:0]          q_c;
	logic                    valid_s6;
	logic                    oor_s6;
	logic [Q_W-1:0]          q_s6;
	logic [Q_W-1:0]          a_s6;
	logic [Q_W-1:0]          b_s6;
	logic signed [LEN_W-1:0] u_s6;
	logic signed [LEN_W-1:0] v_s6;

	assign q_c = r2_s5[Q_W+15:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s6 <= (r2_s5 < ReachLo) || (r2_s5 > ReachHi);
			q_s6   <= q_c;
			a_s6   <= q_c - InnerQ;
			b_s6   <= OuterQ - q_c;
			u_s6   <= u_s5;
			v_s6   <= v_s5;
		end
	end

	// ---------------------------------------------------------------- stage 7
	logic [2*Q_W-1:0] ab_c;
	logic             valid_s7;
	sq_t              sq_s7;

	assign ab_c = a_s6 * b_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s7.oor  <= oor_s6;
			sq_s7.q    <= q_s6;
			sq_s7.u    <= u_s6;
			sq_s7.v    <= v_s6;
			sq_s7.rad  <= ab_c[RAD_W-1:0];
			sq_s7.rem  <= '0;
			sq_s7.root <= '0;
		end
	end

	// ---------------------------------------------------------------- square-root chain
	sq_t             sq_c  [ROOT_W+1];
	logic [ROOT_W:0] sqv_c;

	assign sq_c[0]  = sq_s7;
	assign sqv_c[0] = valid_s7;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		tlapa_sqrt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (adv),
			.prev_valid (sqv_c[g]),
			.prev       (sq_c[g]),
			.next_valid (sqv_c[g+1]),
			.next       (sq_c[g+1])
		);
	end

	// ---------------------------------------------------------------- stage 8
	// Lane 0: elbow angle, lane 1: theta+phi, lane 2: phi of the target.
	sq_t                     sq_e;
	logic signed [CW-1:0]    s_c;
	logic signed [LEN_W-1:0] un_c;
	logic signed [LEN_W-1:0] vn_c;
	logic                    valid_s8;
	cd_t                     cd_s8;

	assign sq_e = sq_c[ROOT_W];
	assign s_c  = $signed(CW'(sq_e.root));
	assign un_c = sq_e.u[LEN_W-1] ? -sq_e.u : sq_e.u;
	assign vn_c = sq_e.u[LEN_W-1] ? -sq_e.v : sq_e.v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s8 <= sqv_c[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cd_s8.oor     <= sq_e.oor;
			cd_s8.lane[0] <= pre_rotate(ElbowQ - $signed(CW'(sq_e.q)), s_c);
			cd_s8.lane[1] <= pre_rotate(ShoulderQ + $signed(CW'(sq_e.q)), s_c);
			cd_s8.lane[2] <= pre_rotate(CW'(un_c), CW'(vn_c));
		end
	end

	// ---------------------------------------------------------------- CORDIC chain
	cd_t                   cd_c  [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] cdv_c;

	assign cd_c[0]  = cd_s8;
	assign cdv_c[0] = valid_s8;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		tlapa_cordic_cell #(
			.STEP (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (adv),
			.prev_valid (cdv_c[g]),
			.prev       (cd_c[g]),
			.next_valid (cdv_c[g+1]),
			.next       (cd_c[g+1])
		);
	end

	// ---------------------------------------------------------------- stage 9
	// Q16 radians to degrees in Q32.
	cd_t                  cd_e;
	logic signed [ZW:0]   dphi_c;
	logic                 valid_s9;
	logic                 oor_s9;
	logic signed [PW-1:0] pa_s9;
	logic signed [PW-1:0] pt_s9;

	assign cd_e   = cd_c[CORDIC_STEPS];
	assign dphi_c = (ZW+1)'(cd_e.lane[1].z) - (ZW+1)'(cd_e.lane[2].z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s9 <= cdv_c[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s9 <= cd_e.oor;
			pa_s9  <= PW'(cd_e.lane[0].z) * RadToDeg;
			pt_s9  <= PW'(dphi_c) * RadToDeg;
		end
	end

	// ---------------------------------------------------------------- stage 10
	logic                 valid_s10;
	logic                 oor_s10;
	logic signed [PW-1:0] ra_s10;
	logic signed [PW-1:0] rt_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s10 <= oor_s9;
			ra_s10  <= (pa_s9 + HalfLsb) >>> 16;
			rt_s10  <= RightQ - ((pt_s9 + HalfLsb) >>> 16);
		end
	end

	// ---------------------------------------------------------------- output register
	// Round to whole degrees, clamp to field range, zero the angles when
	// the point is out of reach.
	logic signed [PW-1:0] ad_c;
	logic signed [PW-1:0] td_c;
	logic [7:0]           lower_c;
	logic signed [8:0]    upper_c;
	logic                 ov_q;
	logic [7:0]           lower_q;
	logic signed [8:0]    upper_q;
	logic                 oor_q;

	assign ad_c = (ra_s10 + HalfLsb) >>> 16;
	assign td_c = (rt_s10 + HalfLsb) >>> 16;

	always_comb begin
		if (oor_s10 || ad_c < 0) begin
			lower_c = 8'd0;
		end else if (ad_c > 44'sd180) begin
			lower_c = 8'd180;
		end else begin
			lower_c = ad_c[7:0];
		end
		if (oor_s10) begin
			upper_c = 9'sd0;
		end else if (td_c < -44'sd90) begin
			upper_c = -9'sd90;
		end else if (td_c > 44'sd180) begin
			upper_c = 9'sd180;
		end else begin
			upper_c = td_c[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lower_q <= lower_c;
			upper_q <= upper_c;
			oor_q   <= oor_s10;
		end
	end

	assign out_valid       = ov_q;
	assign lower_arm_angle = lower_q;
	assign upper_arm_angle = upper_q;
	assign out_of_reach    = oor_q;
endmodule

FILE: rtl/tlapa_checker.sv
// Port-level checks on the result channel of two_link_arm_pixel_angles.
// Self-contained; bound to the top level at the end of this file.
module tlapa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [7:0]        lower_arm_angle,
	input logic signed [8:0] upper_arm_angle,
	input logic              out_of_reach
);

	// hold a stalled beat
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(lower_arm_angle) &&
			$stable(upper_arm_angle) && $stable(out_of_reach))
		else $error("result payload changed while stalled");

	a_reach_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_reach |-> lower_arm_angle == 8'd0 && upper_arm_angle == 9'sd0)
		else $error("out-of-reach beat carries angles");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_reach |-> lower_arm_angle <= 8'd180 &&
			upper_arm_angle >= -9'sd90 && upper_arm_angle <= 9'sd180)
		else $error("angle outside servo range");

endmodule

bind two_link_arm_pixel_angles tlapa_checker u_tlapa_checker (.*);
